// File: rtl/sm3_pkg.sv
`default_nettype none
package sm3_pkg;

  localparam int NumWords = 8;
  localparam int NumRounds = 64;

  localparam logic [31:0] TjLow = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [255:0] Iv = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/sm3_hash_engine_core.sv
`default_nettype none
// SM3 hash engine core. Stream message bytes in one transfer per byte; set
// last_byte on the final transfer (with byte_valid low for a closing transfer
// that carries no byte). Eight 32-bit digest words come out, word 0 first,
// digest_last marking word 7. When the final compression ends, the digest moves
// to its own output register and the engine holds the IV again, so bytes of the
// next message can flow in while the words drain. A closing transfer is held
// off until the previous digest has fully drained.
// Rate: a byte transfer is taken whenever the engine is idle; the 64th byte
// of a block starts a compression, one round per cycle, during which
// input is held off. The message schedule lives in a chain of 16 word cells:
// bytes shift into the chain as they arrive, and each round shifts one
// expanded word in at the tail while the head cell supplies W[j] and the
// fifth cell W[j+4]. A closing transfer pads in place, one byte per cycle,
// and may run one or two compressions before the digest drains one word per
// accepted output transfer.
module sm3_hash_engine_core
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic             digest_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_PAD
  } state_t;

  state_t       state;
  logic [5:0]   fill_count;
  logic [63:0]  bit_length;
  logic [255:0] chain_value;
  logic [255:0] work;
  logic [5:0]   rnd;
  logic         finishing;   // padding pending or running for this message
  logic         len_done;    // pad marker already pushed for this message
  logic [2:0]   out_idx;
  logic [255:0] work_next;
  logic [255:0] digest;      // finished digest, drained one word per transfer

  // fin_block: the block now compressing carries the length field.
  logic fin_block;
  logic pad_is_final;
  // A padding block carries the length when the marker landed at or below 55.
  logic lenblk;

  // Schedule chain: cell 0 is the oldest word, cell 15 the newest.
  logic [31:0] w [16];
  logic        w_load;
  logic [7:0]  w_byte;
  logic        w_shift;
  logic [31:0] w_new;

  assign w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];

  for (genvar k = 0; k < 16; k++) begin : g_cells
    logic [31:0] lw, sw;
    if (k == 15) begin : g_tail
      assign lw = {w[15][23:0], w_byte};
      assign sw = w_new;
    end else begin : g_body
      // Byte loads shift along the whole chain 8 bits at a time.
      assign lw = {w[k][23:0], w[k + 1][31:24]};
      assign sw = w[k + 1];
    end
    sm3_wcell u_cell (
      .clk(clk), .load(w_load), .load_word(lw),
      .shift(w_shift), .shift_word(sw), .word(w[k])
    );
  end

  sm3_round u_round (
    .state_in(work), .rnd(rnd), .wj(w[0]), .wpj(w[0] ^ w[4]), .state_out(work_next)
  );

  logic take;
  // Hold off a closing transfer while the previous digest still drains.
  assign in_ready = (state == S_IDLE) && !(out_valid && last_byte);
  assign take = in_valid && in_ready;

  assign digest_word = digest[255 - 32 * out_idx -: 32];
  assign digest_last = (out_idx == 3'd7);

  // Byte to push in the padding phase.
  logic [7:0] pad_byte;
  always_comb begin
    pad_byte = 8'h00;
    if (!len_done) begin
      pad_byte = PadByte;
    end else if (fill_count >= 6'd56 && lenblk) begin
      pad_byte = bit_length[63 - 8 * (fill_count[2:0]) -: 8];
    end
  end

  always_comb begin
    w_load = 1'b0;
    w_byte = data_byte;
    w_shift = (state == S_COMP);
    if (take && byte_valid) begin
      w_load = 1'b1;
    end else if (take && last_byte) begin
      w_load = 1'b1;
      w_byte = PadByte;
    end else if (state == S_PAD) begin
      w_load = 1'b1;
      w_byte = pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_count <= '0;
      bit_length <= '0;
      chain_value <= Iv;
      finishing <= 1'b0;
      len_done <= 1'b0;
      rnd <= '0;
      out_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drain the digest register; the index wraps back to word 0.
      if (out_valid && out_ready) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          out_valid <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (take && byte_valid) begin
            fill_count <= fill_count + 6'd1;
            bit_length <= bit_length + 64'd8;
            finishing <= last_byte;
            if (fill_count == 6'd63) begin
              state <= S_COMP;
              rnd <= '0;
              work <= chain_value;
            end else if (last_byte) begin
              state <= S_PAD;
            end
          end else if (take && last_byte) begin
            // closing transfer with no byte: push the pad marker now
            finishing <= 1'b1;
            len_done <= 1'b1;
            fill_count <= fill_count + 6'd1;
            if (fill_count == 6'd63) begin
              state <= S_COMP;
              rnd <= '0;
              work <= chain_value;
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // len_done low means the 0x80 marker is still owed
          fill_count <= fill_count + 6'd1;
          if (!len_done) begin
            len_done <= 1'b1;
          end
          if (fill_count == 6'd63) begin
            state <= S_COMP;
            rnd <= '0;
            work <= chain_value;
          end
        end
        S_COMP: begin
          work <= work_next;
          rnd <= rnd + 6'd1;
          if (rnd == 6'(NumRounds - 1)) begin
            fill_count <= '0;
            if (finishing && pad_is_final) begin
              // hand the digest to the output register and reload the IV
              digest <= chain_value ^ work_next;
              out_valid <= 1'b1;
              chain_value <= Iv;
              bit_length <= '0;
              finishing <= 1'b0;
              len_done <= 1'b0;
              state <= S_IDLE;
            end else begin
              chain_value <= chain_value ^ work_next;
              if (!finishing) begin
                state <= S_IDLE;
              end else begin
                state <= S_PAD;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pad_is_final = fin_block;
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_block <= 1'b0;
    end else if (state == S_PAD && fill_count == 6'd63 && len_done) begin
      fin_block <= lenblk;
    end else if (state == S_COMP && rnd == 6'(NumRounds - 1)) begin
      fin_block <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lenblk <= 1'b0;
    end else if (state == S_PAD && !len_done) begin
      lenblk <= (fill_count <= 6'd55);
    end else if (take && !byte_valid && last_byte) begin
      lenblk <= (fill_count <= 6'd55);
    end else if (state == S_COMP && rnd == 6'(NumRounds - 1) && finishing) begin
      lenblk <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_idx))
    else $error("digest index moved while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_COMP |-> !in_ready)
    else $error("input accepted during compression");
  a_iv_after: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> chain_value == Iv)
    else $error("IV not restored");

endmodule
`default_nettype wire

// File: rtl/sm3_wcell.sv
`default_nettype none
// One cell of the message schedule chain: holds one word, loads a byte-shifted
// word during fill, and shifts its word to the neighbor on each round.
module sm3_wcell
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        load,
  input  wire logic [31:0] load_word,
  input  wire logic        shift,
  input  wire logic [31:0] shift_word,
  output logic [31:0]      word
);

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end else if (shift) begin
      word <= shift_word;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sm3_round.sv
`default_nettype none
// One compression round, combinational.
module sm3_round
  import sm3_pkg::*;
(
  input  wire logic [255:0] state_in,
  input  wire logic [5:0]   rnd,
  input  wire logic [31:0]  wj,
  input  wire logic [31:0]  wpj,
  output logic [255:0]      state_out
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    {a, b, c, d, e, f, g, h} = state_in;
    tj = (rnd < 6'd16) ? TjLow : TjHigh;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, rnd[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    ff = (rnd < 6'd16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
    gg = (rnd < 6'd16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
    tt1 = ff + d + ss2 + wpj;
    tt2 = gg + h + ss1 + wj;
    state_out = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
  end

endmodule
`default_nettype wire

// File: sim/tb_sm3_hash_engine_core.sv
`default_nettype none
module tb_sm3_hash_engine_core;
  import sm3_pkg::*;

  // Software model of the digest computation: byte buffer, length, chain.
  class sm3_digest_board;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] nbits;
    logic [31:0] word_q [$];
    logic        tag_q [$];
    int          errors;
    int          words_seen;
    int          messages;

    function new();
      errors = 0;
      words_seen = 0;
      messages = 0;
      restart();
    endfunction

    function void restart();
      for (int k = 0; k < 8; k++) chain[k] = Iv[255 - 32*k -: 32];
      fill = 0;
      nbits = '0;
    endfunction

    function logic [31:0] rl(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [68];
      logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, t1, t2, tj, wp;
      for (int j = 0; j < 16; j++)
        w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
      for (int j = 16; j < 68; j++) begin
        t1 = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
        w[j] = (t1 ^ rl(t1, 15) ^ rl(t1, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int j = 0; j < 64; j++) begin
        tj = (j < 16) ? TjLow : TjHigh;
        a12 = rl(a, 12);
        ss1 = rl(a12 + e + rl(tj, j), 7);
        ss2 = ss1 ^ a12;
        ff = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
        gg = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
        wp = w[j] ^ w[j+4];
        t1 = ff + d + ss2 + wp;
        t2 = gg + h + ss1 + w[j];
        d = c; c = rl(b, 9); b = a; a = t1;
        h = g; g = rl(f, 19); f = e;
        e = t2 ^ rl(t2, 9) ^ rl(t2, 17);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endfunction

    // Note one accepted input transfer; queue the digest when it closes.
    function void note_input(logic [7:0] db, logic bv, logic lb);
      if (bv) begin
        blk[fill] = db;
        fill++;
        nbits += 64'd8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!lb) return;
      blk[fill] = PadByte;
      fill++;
      if (fill > 56) begin
        for (int k = fill; k < 64; k++) blk[k] = '0;
        compress();
        fill = 0;
      end
      for (int k = fill; k < 56; k++) blk[k] = '0;
      for (int k = 0; k < 8; k++) blk[63-k] = nbits[8*k +: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        word_q.push_back(chain[k]);
        tag_q.push_back(k == 7);
      end
      messages++;
      restart();
    endfunction

    function void check_word(logic [31:0] wd, logic tg);
      logic [31:0] ew;
      logic et;
      words_seen++;
      if (word_q.size() == 0) begin
        $error("digest word %h arrived with none expected", wd);
        errors++;
        return;
      end
      ew = word_q.pop_front();
      et = tag_q.pop_front();
      if (wd !== ew) begin
        $error("digest_word: expected %h, got %h", ew, wd);
        errors++;
      end
      if (tg !== et) begin
        $error("digest_last: expected %b, got %b", et, tg);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  sm3_digest_board board = new();
  int  cycle_count = 0;
  bit  calm = 1'b0;     // no idling on either side while set
  bit  hold_off = 1'b0; // receiver stalls for a long stretch while set
  int  sent = 0;

  localparam int CycleLimit = 400000;

  sm3_hash_engine_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_valid(byte_valid), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .digest_last(digest_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every output transfer against the oldest queued digest word.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_word(digest_word, digest_last);
  end

  // Receiver: random stalls, none while calm, a long stall while hold_off.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 10);
  end

  // Offer one transfer and hold it until accepted; idle first at random.
  task automatic send_item(logic [7:0] db, logic bv, logic lb);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= db;
    byte_valid <= bv;
    last_byte <= lb;
    do @(posedge clk); while (!in_ready);
    board.note_input(db, bv, lb);
    sent++;
    @(negedge clk);
  endtask

  // Send a message of n random bytes; close with a byte or an empty transfer.
  task automatic send_message(int n);
    bit empty_close;
    empty_close = (n == 0) || ($urandom_range(3) == 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(15) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (k == n - 1) && !empty_close);
    end
    if (empty_close) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, "abc", extreme bytes.
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);

    // Random messages; sizes cross the 55/56 and 64-byte edges.
    while (sent < 430) begin
      case ($urandom_range(5))
        0: send_message($urandom_range(0, 3));
        1: send_message($urandom_range(54, 57));
        2: send_message($urandom_range(62, 66));
        default: send_message($urandom_range(4, 40));
      endcase
      if (sent > 150 && sent < 260) calm = 1'b1;
      else calm = 1'b0;
    end

    // Pressure: stall the receiver while four messages are offered, so closing transfers are held off.
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int m = 0; m < 4; m++) send_message($urandom_range(1, 20));
      end
    join
    in_valid <= 1'b0;

    while (board.word_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d input transfers, %0d messages, %0d digest words checked.",
             sent, board.messages, board.words_seen);
    if (board.errors == 0 && board.word_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sm3_hash_engine_core.f
rtl/sm3_pkg.sv
rtl/sm3_wcell.sv
rtl/sm3_round.sv
rtl/sm3_hash_engine_core.sv
sim/tb_sm3_hash_engine_core.sv
